// ===== hw/rtl/sliding_window_rate_meter_macros.svh =====
// ----------------------------------------------------------------------------
// sliding_window_rate_meter_macros.svh
// Assertion shorthands used by the rate meter checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RATE_METER_MACROS_SVH
`define SLIDING_WINDOW_RATE_METER_MACROS_SVH

// Clocked check, masked while reset is held.
`define SWRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also covers the reset cycles.
`define SWRM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/swrm_pkg.sv =====
// ----------------------------------------------------------------------------
// swrm_pkg
// Shared widths, constants, codes and types of the sliding window rate meter.
// ----------------------------------------------------------------------------
package swrm_pkg;

    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    localparam int TIME_W  = 48;
    localparam int BYTES_W = 16;
    localparam int TOTAL_W = 64;
    localparam int RATE_W  = 40;
    localparam int CFG_W   = 40;
    localparam int CFG_IDX_W = 2;

    // bytes * 8 * 1e9: the 1e9 goes through the multiplier, the 8 is a shift
    localparam int NSPS_W  = 30;
    localparam logic [NSPS_W-1:0] NS_PER_S = NSPS_W'(1000000000);
    localparam int HALF_W  = TOTAL_W / 2;
    localparam int PP_W    = HALF_W + NSPS_W;
    localparam int SUM_W   = PP_W + HALF_W;
    localparam int NUM_W   = SUM_W + 3;
    localparam int HI_W    = NUM_W - RATE_W;
    localparam int DCNT_W  = $clog2(RATE_W + 1);

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    localparam logic [CFG_W-1:0] WINDOW_RST  = CFG_W'(100000000);
    localparam logic [CFG_W-1:0] SPACING_RST = CFG_W'(1000000);

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = CFG_IDX_W'(2);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_RD_NEW,
        ST_CHK,
        ST_MUL0,
        ST_MUL1,
        ST_SUM,
        ST_SAT,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [TOTAL_W-1:0] total;
    } t_sample;

    typedef struct packed {
        logic               we;
        logic [RING_AW-1:0] addr;
        t_sample            data;
    } t_ring_wr;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] rem;
        logic [RATE_W-1:0] low;
        logic [TIME_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [RATE_W-1:0] quo;
    } t_div_sts;

endpackage

// ===== hw/rtl/swrm_ring.sv =====
// ----------------------------------------------------------------------------
// swrm_ring
// Sample ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module swrm_ring (
    input  logic                          i_clk,
    input  swrm_pkg::t_ring_wr            i_wr,
    input  logic [swrm_pkg::RING_AW-1:0]  i_rd_addr,
    output swrm_pkg::t_sample             o_rd_data
);

    swrm_pkg::t_sample r_mem [swrm_pkg::RING_DEPTH];
    swrm_pkg::t_sample r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/swrm_div.sv =====
// ----------------------------------------------------------------------------
// swrm_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swrm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swrm_pkg::t_div_req i_req,
    output swrm_pkg::t_div_sts o_sts
);

    logic [swrm_pkg::TIME_W-1:0] r_rem;
    logic [swrm_pkg::RATE_W-1:0] r_q;
    logic [swrm_pkg::TIME_W-1:0] r_dv;
    logic [swrm_pkg::DCNT_W-1:0] r_cnt;
    logic                        r_busy;

    logic [swrm_pkg::TIME_W:0] trial;
    logic [swrm_pkg::TIME_W:0] diff;
    logic                      ge;

    // rem < divisor holds throughout, so the trial stays below twice it
    assign trial = {r_rem, r_q[swrm_pkg::RATE_W-1]};
    assign ge    = (trial >= {1'b0, r_dv});
    assign diff  = trial - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= swrm_pkg::DCNT_W'(swrm_pkg::RATE_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == swrm_pkg::DCNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_q   <= i_req.low;
            r_dv  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[swrm_pkg::TIME_W-1:0] : trial[swrm_pkg::TIME_W-1:0];
            r_q   <= {r_q[swrm_pkg::RATE_W-2:0], ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.quo  = r_q;

endmodule

// ===== hw/rtl/sliding_window_rate_meter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rate_meter
// Packet throughput over a sliding time window, in bits per second.
// ----------------------------------------------------------------------------
// Takes one packet beat at a time and holds o_in_stall until it is done with
// it. A packet while disabled is taken without a stall; the first packet
// into an empty ring goes through ST_FIRST; one that stores or skips a
// sample but yields no rate goes through ST_RD_NEW and ST_CHK. A packet that
// yields a rate needs two ring reads, a 64x30 product in two halves on one
// multiplier, then a 40-step restoring divider, plus any wait for the output
// register to free. Saturated rates skip the divider. A pending result does
// not block the next packet beat.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [swrm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [swrm_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [swrm_pkg::TIME_W-1:0]        i_time_ns,
    input  logic [swrm_pkg::BYTES_W-1:0]       i_packet_bytes,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [swrm_pkg::TIME_W-1:0]        o_stamp_ns,
    output logic [swrm_pkg::RATE_W-1:0]        o_rate_bps
);

    swrm_pkg::t_state r_state, n_state;

    logic                         r_enable;
    logic [swrm_pkg::CFG_W-1:0]   r_window;
    logic [swrm_pkg::CFG_W-1:0]   r_spacing;

    logic [swrm_pkg::TOTAL_W-1:0] r_total;
    logic [swrm_pkg::TIME_W-1:0]  r_time;
    logic [swrm_pkg::RING_AW-1:0] r_head;
    logic [swrm_pkg::RING_AW-1:0] r_tail;
    logic [swrm_pkg::CNT_W-1:0]   r_count;

    logic [swrm_pkg::TIME_W-1:0]  r_dt;
    logic [swrm_pkg::TOTAL_W-1:0] r_diff;
    logic [swrm_pkg::PP_W-1:0]    r_plo;
    logic [swrm_pkg::PP_W-1:0]    r_phi;
    logic [swrm_pkg::NUM_W-1:0]   r_num;
    logic                         r_sat;

    logic                         r_out_valid;
    logic [swrm_pkg::TIME_W-1:0]  r_stamp;
    logic [swrm_pkg::RATE_W-1:0]  r_rate;

    swrm_pkg::t_ring_wr           ring_wr;
    swrm_pkg::t_sample            rd_data;
    logic [swrm_pkg::RING_AW-1:0] rd_addr;
    swrm_pkg::t_div_req           div_req;
    swrm_pkg::t_div_sts           div_sts;

    logic                         in_acc;
    logic                         push;
    logic                         pop;
    logic                         load_out;
    logic                         ring_full;
    logic                         spaced;
    logic                         aged;
    logic                         sat;
    logic [swrm_pkg::RING_AW-1:0] head_nxt;
    logic [swrm_pkg::RING_AW-1:0] tail_nxt;
    logic [swrm_pkg::RING_AW-1:0] tail_prv;
    logic [swrm_pkg::TIME_W:0]    newest_lim;
    logic [swrm_pkg::TIME_W:0]    oldest_lim;
    logic [swrm_pkg::HALF_W-1:0]  mul_a;
    logic [swrm_pkg::PP_W-1:0]    mul_p;
    logic [swrm_pkg::SUM_W-1:0]   prod_sum;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign ring_full = (r_count == swrm_pkg::CNT_W'(swrm_pkg::RING_DEPTH));

    assign head_nxt = (r_head == swrm_pkg::RING_AW'(swrm_pkg::RING_DEPTH - 1))
                      ? '0 : r_head + 1'b1;
    assign tail_nxt = (r_tail == swrm_pkg::RING_AW'(swrm_pkg::RING_DEPTH - 1))
                      ? '0 : r_tail + 1'b1;
    assign tail_prv = (r_tail == '0) ? swrm_pkg::RING_AW'(swrm_pkg::RING_DEPTH - 1)
                                     : r_tail - 1'b1;

    // rd_data holds the newest sample in ST_RD_NEW and the oldest in ST_CHK
    assign newest_lim = {1'b0, rd_data.stamp} + {9'd0, r_spacing};
    assign oldest_lim = {1'b0, rd_data.stamp} + {9'd0, r_window};
    assign spaced     = ({1'b0, r_time} >= newest_lim);
    assign aged       = ({1'b0, r_time} >= oldest_lim);

    assign mul_a    = (r_state == swrm_pkg::ST_MUL0) ? r_diff[swrm_pkg::HALF_W-1:0]
                                                     : r_diff[swrm_pkg::TOTAL_W-1:swrm_pkg::HALF_W];
    assign mul_p    = swrm_pkg::PP_W'(mul_a) * swrm_pkg::PP_W'(swrm_pkg::NS_PER_S);
    assign prod_sum = {r_phi, {swrm_pkg::HALF_W{1'b0}}} + swrm_pkg::SUM_W'(r_plo);

    // quotient would need more than RATE_W bits; also catches dt == 0
    assign sat = (r_num[swrm_pkg::NUM_W-1:swrm_pkg::RATE_W] >= swrm_pkg::HI_W'(r_dt));

    always_comb begin
        n_state       = r_state;
        push          = 1'b0;
        pop           = 1'b0;
        load_out      = 1'b0;
        rd_addr       = r_head;
        div_req.start   = 1'b0;
        div_req.rem     = r_num[swrm_pkg::RATE_W +: swrm_pkg::TIME_W];
        div_req.low     = r_num[swrm_pkg::RATE_W-1:0];
        div_req.divisor = r_dt;
        case (r_state)
            swrm_pkg::ST_IDLE: begin
                rd_addr = tail_prv;
                if (in_acc && r_enable) begin
                    n_state = (r_count == '0) ? swrm_pkg::ST_FIRST : swrm_pkg::ST_RD_NEW;
                end
            end
            swrm_pkg::ST_FIRST: begin
                push    = 1'b1;
                n_state = swrm_pkg::ST_IDLE;
            end
            swrm_pkg::ST_RD_NEW: begin
                push    = spaced && !ring_full;
                n_state = swrm_pkg::ST_CHK;
            end
            swrm_pkg::ST_CHK: begin
                if (aged) begin
                    pop     = 1'b1;
                    n_state = swrm_pkg::ST_MUL0;
                end else begin
                    n_state = swrm_pkg::ST_IDLE;
                end
            end
            swrm_pkg::ST_MUL0: n_state = swrm_pkg::ST_MUL1;
            swrm_pkg::ST_MUL1: n_state = swrm_pkg::ST_SUM;
            swrm_pkg::ST_SUM:  n_state = swrm_pkg::ST_SAT;
            swrm_pkg::ST_SAT: begin
                if (sat) begin
                    n_state = swrm_pkg::ST_EMIT;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = swrm_pkg::ST_DIV;
                end
            end
            swrm_pkg::ST_DIV: begin
                if (!div_sts.busy) begin
                    n_state = swrm_pkg::ST_EMIT;
                end
            end
            swrm_pkg::ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = swrm_pkg::ST_IDLE;
                end
            end
            default: n_state = swrm_pkg::ST_IDLE;
        endcase
    end

    assign ring_wr.we         = push;
    assign ring_wr.addr       = r_tail;
    assign ring_wr.data.stamp = r_time;
    assign ring_wr.data.total = r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swrm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b1;
            r_window  <= swrm_pkg::WINDOW_RST;
            r_spacing <= swrm_pkg::SPACING_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                swrm_pkg::CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                swrm_pkg::CFG_WINDOW:  r_window  <= i_cfg_data;
                swrm_pkg::CFG_SPACING: r_spacing <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (in_acc && r_enable) begin
                r_total <= r_total + swrm_pkg::TOTAL_W'(i_packet_bytes);
            end
            if (push) begin
                r_tail  <= tail_nxt;
                r_count <= r_count + 1'b1;
            end else if (pop) begin
                r_head  <= head_nxt;
                r_count <= r_count - 1'b1;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_time <= i_time_ns;
        end
        if (pop) begin
            r_dt   <= r_time - rd_data.stamp;
            r_diff <= r_total - rd_data.total;
        end
        if (r_state == swrm_pkg::ST_MUL0) begin
            r_plo <= mul_p;
        end
        if (r_state == swrm_pkg::ST_MUL1) begin
            r_phi <= mul_p;
        end
        if (r_state == swrm_pkg::ST_SUM) begin
            r_num <= {prod_sum, 3'b000};
        end
        if (r_state == swrm_pkg::ST_SAT) begin
            r_sat <= sat;
        end
        if (load_out) begin
            r_stamp <= r_time;
            r_rate  <= r_sat ? swrm_pkg::RATE_MAX : div_sts.quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    swrm_ring u_ring (
        .i_clk     (i_clk),
        .i_wr      (ring_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    swrm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts)
    );

    assign o_in_stall  = (r_state != swrm_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_stamp_ns  = r_stamp;
    assign o_rate_bps  = r_rate;

endmodule

// ===== hw/rtl/swrm_checker.sv =====
// ----------------------------------------------------------------------------
// swrm_checker
// Port-level checks of the rate meter, bound onto the top level.
// ----------------------------------------------------------------------------
`include "sliding_window_rate_meter_macros.svh"

module swrm_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [swrm_pkg::TIME_W-1:0]        o_stamp_ns,
    input logic [swrm_pkg::RATE_W-1:0]        o_rate_bps
);

    logic in_beat;

    assign in_beat = i_in_valid && !o_in_stall;

    // stalled result beat holds
    `SWRM_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_stamp_ns) && $stable(o_rate_bps)), "result beat changed while stalled")

    // reset leaves the block ready and with nothing to deliver
    `SWRM_ASSERT_RST(a_rst_clear, (!i_rst_n) |=> (!o_in_stall && !o_out_valid), "reset did not clear handshake state")

    // a new result only comes out of a packet still being worked on
    `SWRM_ASSERT(a_rise_busy, $rose(o_out_valid) |-> $past(o_in_stall), "result appeared while input side was idle")

    // no result can come out of a packet in the cycle right after its beat
    `SWRM_ASSERT(a_no_fast, in_beat |=> !$rose(o_out_valid), "result too soon after input beat")

endmodule

bind sliding_window_rate_meter swrm_checker u_swrm_checker (.*);
